// ===== rtl/qvr_pkg.sv =====
package qvr_pkg;

	localparam int VEC_W      = 16;
	localparam int QUAT_W     = 16;
	localparam int ROT_W      = 17;
	localparam int FRAC_SHIFT = 28;

	// q * v products, three-term sums, t * q products, four-term sums
	localparam int P1_W  = QUAT_W + VEC_W;
	localparam int T_W   = P1_W + 1;
	localparam int P2_W  = T_W + QUAT_W;
	localparam int ACC_W = P2_W + 2;
	localparam int SHR_W = ACC_W - FRAC_SHIFT;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;
	localparam int CFG_ADDR_W = 2;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (FRAC_SHIFT - 1);
	localparam logic signed [ROT_W-1:0] ROT_MAX = {1'b0, {(ROT_W-1){1'b1}}};
	localparam logic signed [ROT_W-1:0] ROT_MIN = {1'b1, {(ROT_W-1){1'b0}}};

	localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(16384);

	typedef logic signed [VEC_W-1:0]  vec_t;
	typedef logic signed [QUAT_W-1:0] quat_t;
	typedef logic signed [P1_W-1:0]   prod1_t;
	typedef logic signed [T_W-1:0]    tsum_t;
	typedef logic signed [P2_W-1:0]   prod2_t;
	typedef logic signed [SHR_W-1:0]  shr_t;
	typedef logic signed [ROT_W-1:0]  rot_t;

	// register indexes, also the component order of the stored quaternion
	typedef enum logic [CFG_ADDR_W-1:0] {
		QUAT_REAL = 2'd0,
		QUAT_I    = 2'd1,
		QUAT_J    = 2'd2,
		QUAT_K    = 2'd3
	} quat_idx_t;

	typedef struct packed {
		rot_t rot;
		logic sat;
	} fin_t;

endpackage

// ===== rtl/quaternion_vector_rotate.sv =====
// channel  dir  signals                        contents (lsb first)
// s_axis   in   s_tvalid s_tready s_tdata      vec_x[15:0] vec_y[31:16] vec_z[47:32]
// m_axis   out  m_tvalid m_tready m_tdata      rot_x[16:0] rot_y[33:17] rot_z[50:34]
//               m_tuser                        saturated
// cfg      in   cfg_valid cfg_ready cfg_addr   0 quat_real 1 quat_i 2 quat_j 3 quat_k
//               cfg_data
//
// five register stages: q*v products, t sums, t*q products, rounded sums, saturated output
// one item per cycle while the output is not stalled; m_tvalid rises when the item reaches
// the saturated output stage, and the result leaves on an edge with m_tready high
// each stage loads when empty or when the stage after it moves, so bubbles close up
// and s_tready stays high while any stage has room, also under an output stall
// reset clears the valid bits and loads the identity quaternion; cfg_ready is always high
module quaternion_vector_rotate
	import qvr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // vec_x, vec_y, vec_z
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // rot_x, rot_y, rot_z, zero fill
	output logic                  m_tuser,   // saturated
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [QUAT_W-1:0]     cfg_data
);

	quat_t quat_q [4];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	prod1_t p_s1 [4][3];
	tsum_t  t_s2 [4];
	prod2_t p_s3 [3][4];
	shr_t   acc_s4 [3];
	rot_t   rot_s5 [3];
	logic   sat_s5;

	vec_t   vec [3];
	prod1_t p_d [4][3];
	tsum_t  t_d [4];
	prod2_t p3_d [3][4];
	shr_t   acc_d [3];
	fin_t   fin [3];
	logic signed [ACC_W-1:0] sum_d [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[QUAT_REAL] <= QUAT_ONE;
			quat_q[QUAT_I]    <= '0;
			quat_q[QUAT_J]    <= '0;
			quat_q[QUAT_K]    <= '0;
		end else if (cfg_valid) begin
			quat_q[quat_idx_t'(cfg_addr)] <= cfg_data;
		end
	end

	// stall chain
	assign en_s5    = !v_s5 || m_tready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign vec[0] = s_tdata[VEC_W-1:0];
	assign vec[1] = s_tdata[2*VEC_W-1:VEC_W];
	assign vec[2] = s_tdata[3*VEC_W-1:2*VEC_W];

	always_comb begin
		for (int a = 0; a < 4; a++) begin
			for (int b = 0; b < 3; b++) begin
				p_d[a][b] = quat_q[a] * vec[b];
			end
		end
	end

	// t = q * (0, v)
	always_comb begin
		t_d[QUAT_REAL] = -T_W'(p_s1[QUAT_I][0]) - T_W'(p_s1[QUAT_J][1])
			- T_W'(p_s1[QUAT_K][2]);
		t_d[QUAT_I] = T_W'(p_s1[QUAT_REAL][0]) + T_W'(p_s1[QUAT_J][2])
			- T_W'(p_s1[QUAT_K][1]);
		t_d[QUAT_J] = T_W'(p_s1[QUAT_REAL][1]) + T_W'(p_s1[QUAT_K][0])
			- T_W'(p_s1[QUAT_I][2]);
		t_d[QUAT_K] = T_W'(p_s1[QUAT_REAL][2]) + T_W'(p_s1[QUAT_I][1])
			- T_W'(p_s1[QUAT_J][0]);
	end

	// t * conj(q), vector part; terms 0 and 2 are subtracted
	always_comb begin
		p3_d[0][0] = P2_W'(t_s2[QUAT_REAL]) * P2_W'(quat_q[QUAT_I]);
		p3_d[0][1] = P2_W'(t_s2[QUAT_I])    * P2_W'(quat_q[QUAT_REAL]);
		p3_d[0][2] = P2_W'(t_s2[QUAT_J])    * P2_W'(quat_q[QUAT_K]);
		p3_d[0][3] = P2_W'(t_s2[QUAT_K])    * P2_W'(quat_q[QUAT_J]);
		p3_d[1][0] = P2_W'(t_s2[QUAT_REAL]) * P2_W'(quat_q[QUAT_J]);
		p3_d[1][1] = P2_W'(t_s2[QUAT_J])    * P2_W'(quat_q[QUAT_REAL]);
		p3_d[1][2] = P2_W'(t_s2[QUAT_K])    * P2_W'(quat_q[QUAT_I]);
		p3_d[1][3] = P2_W'(t_s2[QUAT_I])    * P2_W'(quat_q[QUAT_K]);
		p3_d[2][0] = P2_W'(t_s2[QUAT_REAL]) * P2_W'(quat_q[QUAT_K]);
		p3_d[2][1] = P2_W'(t_s2[QUAT_K])    * P2_W'(quat_q[QUAT_REAL]);
		p3_d[2][2] = P2_W'(t_s2[QUAT_I])    * P2_W'(quat_q[QUAT_J]);
		p3_d[2][3] = P2_W'(t_s2[QUAT_J])    * P2_W'(quat_q[QUAT_I]);
	end

	// add half, then keep the integer bits: floor shift by the fraction width
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_d[c] = -ACC_W'(p_s3[c][0]) + ACC_W'(p_s3[c][1])
				- ACC_W'(p_s3[c][2]) + ACC_W'(p_s3[c][3]) + ROUND_HALF;
			acc_d[c] = sum_d[c][ACC_W-1:FRAC_SHIFT];
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_fin
		qvr_finish u_finish (
			.acc (acc_s4[g]),
			.res (fin[g])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s1) p_s1 <= p_d;
		if (en_s2) t_s2 <= t_d;
		if (en_s3) p_s3 <= p3_d;
		if (en_s4) acc_s4 <= acc_d;
		if (en_s5) begin
			for (int c = 0; c < 3; c++) begin
				rot_s5[c] <= fin[c].rot;
			end
			sat_s5 <= fin[0].sat || fin[1].sat || fin[2].sat;
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {{(OUT_DATA_W - 3*ROT_W){1'b0}}, rot_s5[2], rot_s5[1], rot_s5[0]};
	assign m_tuser  = sat_s5;

`ifndef SYNTHESIS
	a_sat_at_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
			(rot_s5[0] == ROT_MAX || rot_s5[0] == ROT_MIN ||
			 rot_s5[1] == ROT_MAX || rot_s5[1] == ROT_MIN ||
			 rot_s5[2] == ROT_MAX || rot_s5[2] == ROT_MIN))
		else $error("saturated flag without a clipped component");

	a_ready_only_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !m_tready))
		else $error("input held off while the pipeline has room");

	a_full_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && v_s5 && m_tready) |=> v_s5)
		else $error("item lost between last two stages");
`endif

endmodule

// ===== rtl/qvr_finish.sv =====
module qvr_finish
	import qvr_pkg::*;
(
	input  shr_t acc,
	output fin_t res
);

	always_comb begin
		if (acc > SHR_W'(ROT_MAX)) begin
			res.rot = ROT_MAX;
			res.sat = 1'b1;
		end else if (acc < SHR_W'(ROT_MIN)) begin
			res.rot = ROT_MIN;
			res.sat = 1'b1;
		end else begin
			res.rot = acc[ROT_W-1:0];
			res.sat = 1'b0;
		end
	end

endmodule
